/* rtl/lsm_pkg.sv */
// Shared types, register indexes and character helpers for the line substring matcher.
`timescale 1ns / 1ps
package lsm_pkg;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_A_LOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_A_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_A_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_B_LOW    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_B_HIGH   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_B_LENGTH = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_CASE      = 3'd6;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic        has_search_pattern;
      logic        has_boundary_pattern;
      logic        is_blank;
      logic [7:0]  piece_length;
      logic [23:0] piece_index;
   } rsp_type;

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
      logic [4:0]  length;
      logic        ignore_case;
   } pattern_cfg_type;

   typedef struct packed {
      logic step;    // advance the partial-match vector with this byte
      logic clear;   // piece ends: drop all partial matches
   } match_ctl_type;

   function automatic logic [7:0] fold_char(input logic [7:0] c, input logic ignore_case);
      logic [7:0] r;
      r = c;
      if (ignore_case && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

/* rtl/lsm_csr.sv */
// Configuration register file: pattern bytes, lengths and the case-fold flag.
`timescale 1ns / 1ps
module lsm_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write,
   input  logic [lsm_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [63:0]                             csr_wdata,
   output lsm_pkg::pattern_cfg_type                pattern_a,
   output lsm_pkg::pattern_cfg_type                pattern_b
);
   import lsm_pkg::*;

   logic [63:0] a_low_ff, a_high_ff, b_low_ff, b_high_ff;
   logic [4:0]  a_len_ff, b_len_ff;
   logic        fold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_low_ff  <= '0;
         a_high_ff <= '0;
         a_len_ff  <= '0;
         b_low_ff  <= '0;
         b_high_ff <= '0;
         b_len_ff  <= '0;
         fold_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_A_LOW:    a_low_ff  <= csr_wdata;
            CSR_PATTERN_A_HIGH:   a_high_ff <= csr_wdata;
            CSR_PATTERN_A_LENGTH: a_len_ff  <= csr_wdata[4:0];
            CSR_PATTERN_B_LOW:    b_low_ff  <= csr_wdata;
            CSR_PATTERN_B_HIGH:   b_high_ff <= csr_wdata;
            CSR_PATTERN_B_LENGTH: b_len_ff  <= csr_wdata[4:0];
            CSR_IGNORE_CASE:      fold_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign pattern_a = '{low: a_low_ff, high: a_high_ff, length: a_len_ff, ignore_case: fold_ff};
   assign pattern_b = '{low: b_low_ff, high: b_high_ff, length: b_len_ff, ignore_case: fold_ff};

endmodule

/* rtl/lsm_match.sv */
// Shift-and partial-match vector and seen flag for one pattern.
`timescale 1ns / 1ps
module lsm_match #(
   parameter int PATTERN_BYTES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lsm_pkg::pattern_cfg_type  cfg,
   input  lsm_pkg::match_ctl_type    ctl,
   input  logic [7:0]                text_byte,
   output logic                      seen_now
);
   import lsm_pkg::*;

   localparam int LEN_BITS  = $clog2(PATTERN_BYTES + 1);
   localparam int PAD_BYTES = (PATTERN_BYTES > 16) ? PATTERN_BYTES : 16;
   localparam int PAD_BITS  = 8 * PAD_BYTES;

   logic [PATTERN_BYTES-1:0] vec_ff, vec_in, hits, step_vec;
   logic                     seen_ff, seen_in, end_hit;
   logic [LEN_BITS-1:0]      len_eff;
   logic [PAD_BITS-1:0]      pat_bytes;
   logic [7:0]               text_fold;

   always_comb begin
      // Lengths above the vector width clamp; bytes past the register pair read as zero.
      len_eff   = (int'(cfg.length) > PATTERN_BYTES) ? LEN_BITS'(PATTERN_BYTES)
                                                     : LEN_BITS'(cfg.length);
      pat_bytes = PAD_BITS'({cfg.high, cfg.low});
      text_fold = fold_char(text_byte, cfg.ignore_case);
      hits      = '0;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         hits[k] = (k < int'(len_eff)) &&
                   (fold_char(pat_bytes[8*k +: 8], cfg.ignore_case) == text_fold);
      end
      step_vec = ((vec_ff << 1) | PATTERN_BYTES'(1)) & hits;
      end_hit  = 1'b0;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         end_hit = end_hit | (step_vec[k] & ((k + 1) == int'(len_eff)));
      end
      seen_now = seen_ff | (ctl.step & end_hit) | (len_eff == '0);

      vec_in  = vec_ff;
      seen_in = seen_ff;
      if (ctl.clear) begin
         vec_in  = '0;
         seen_in = 1'b0;
      end else if (ctl.step) begin
         vec_in  = step_vec;
         seen_in = seen_ff | end_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff  <= '0;
         seen_ff <= 1'b0;
      end else begin
         vec_ff  <= vec_in;
         seen_ff <= seen_in;
      end
   end

endmodule

/* rtl/line_substring_match.sv */
// Top level: byte stream substring matcher that reports one result per text piece.
`timescale 1ns / 1ps
// Usage
//   req_*  : one text byte per item plus an end-of-input flag (valid/ready).
//   rsp_*  : one item per closed piece: search and boundary pattern hits,
//            blank flag, piece length and piece index (valid/ready).
//   csr_*  : register writes (index, 64-bit data); always ready. Write only
//            while no item is in flight.
//   A piece closes on a newline byte, on its PIECE_BYTES-th byte, or on a
//   byte flagged end_of_input; the closing byte belongs to the piece.
// Timing
//   An accepted item sits in the input register, is then folded into the
//   piece state, and a closing item then loads the result register (rsp_valid).
//   One item per cycle unless stalled as below; the per-byte
//   match compare between the input register and the state registers sets it.
// Reset
//   Clears valid flags, CSRs, piece state and piece counter, not the payload.
// Stall
//   While the result register holds an untaken item, a closing byte waits
//   in the input register; bytes that close nothing keep flowing.
module line_substring_match #(
   parameter int PATTERN_BYTES = 16,
   parameter int PIECE_BYTES   = 255,
   parameter int COUNT_BITS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lsm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lsm_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lsm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [63:0]                         csr_wdata
);
   import lsm_pkg::*;

   localparam int CNT_BITS = $clog2(PIECE_BYTES + 1);

   pattern_cfg_type pattern_a, pattern_b;
   match_ctl_type   match_ctl;
   logic            search_now, boundary_now;

   // input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // piece state
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in, cnt_next;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic                  blank_ff, blank_in, nul_ff, nul_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic can_out, fire, ends, nul_now, update, nonblank, blank_now;

   assign csr_ready = 1'b1;

   lsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pattern_a (pattern_a),
      .pattern_b (pattern_b)
   );

   lsm_match #(.PATTERN_BYTES(PATTERN_BYTES)) u_match_search (
      .clock     (clock),
      .reset     (reset),
      .cfg       (pattern_a),
      .ctl       (match_ctl),
      .text_byte (in_data_ff.text_byte),
      .seen_now  (search_now)
   );

   lsm_match #(.PATTERN_BYTES(PATTERN_BYTES)) u_match_boundary (
      .clock     (clock),
      .reset     (reset),
      .cfg       (pattern_b),
      .ctl       (match_ctl),
      .text_byte (in_data_ff.text_byte),
      .seen_now  (boundary_now)
   );

   always_comb begin
      can_out  = !rsp_valid_ff || rsp_ready;
      cnt_next = cnt_ff + CNT_BITS'(1);
      // close the piece on newline, a full piece, or the last byte of input
      ends     = in_data_ff.end_of_input || (in_data_ff.text_byte == CHAR_LF) ||
                 (cnt_next >= CNT_BITS'(PIECE_BYTES));
      // advance the held byte unless it closes a piece and the result slot is full
      fire     = in_valid_ff && (!ends || can_out);
      // a NUL byte hides the rest of the piece from matching and the blank test
      nul_now  = (in_data_ff.text_byte == CHAR_NUL) || nul_ff;
      update   = fire && !nul_now;
      nonblank = (in_data_ff.text_byte != CHAR_SPACE) && (in_data_ff.text_byte != CHAR_TAB) &&
                 (in_data_ff.text_byte != CHAR_LF);
      blank_now = blank_ff && !(update && nonblank);

      match_ctl.step  = update;
      match_ctl.clear = fire && ends;

      req_ready   = !in_valid_ff || fire;
      in_valid_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      blank_in = blank_ff;
      nul_in   = nul_ff;
      if (fire) begin
         if (ends) begin
            cnt_in   = '0;
            idx_in   = idx_ff + COUNT_BITS'(1);
            blank_in = 1'b1;
            nul_in   = 1'b0;
         end else begin
            cnt_in   = cnt_next;
            blank_in = blank_now;
            nul_in   = nul_now;
         end
      end

      rsp_data_in.has_search_pattern   = search_now;
      rsp_data_in.has_boundary_pattern = boundary_now;
      rsp_data_in.is_blank             = blank_now;
      rsp_data_in.piece_length         = 8'(cnt_next);
      rsp_data_in.piece_index          = 24'(idx_ff);

      if (fire && ends) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         blank_ff     <= 1'b1;
         nul_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         blank_ff     <= blank_in;
         nul_ff       <= nul_in;
      end
   end

   // payload registers: input loads on accept, result on a piece close; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire && ends) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the byte count never reaches a full piece between items
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) < PIECE_BYTES)
      else $error("piece byte count out of range");

   // a closed piece leaves fresh piece state behind
   a_piece_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && ends) |=> (cnt_ff == '0) && blank_ff && !nul_ff)
      else $error("piece state not cleared after close");

   // each closed piece advances the index by exactly one
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (fire && ends) |=> (idx_ff == COUNT_BITS'($past(idx_ff) + COUNT_BITS'(1))))
      else $error("piece index did not advance by one");

   // a closing byte never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(fire && ends))
      else $error("result overwritten while stalled");

endmodule

/* bench/testbench.sv */
// Self-checking bench for the line substring matcher: random text lines against a shift-and predictor.
`timescale 1ns / 1ps
module testbench;
   import lsm_pkg::*;

   // Longest piece before a forced split, and the widest pattern.
   localparam int LINE_SPLIT_BYTES = 255;
   localparam int PATTERN_SLOTS    = 16;
   // Cycles to let the block settle after the last result of a phase.
   localparam int SETTLE_CYCLES    = 8;
   // Length of the long receiver hold-off that backs up the block.
   localparam int LONG_HOLD_CYCLES = 300;
   // Minimum random items per configuration block; the last line may run past it.
   localparam int BLOCK_ITEMS      = 85;

   // Every driven input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // Text bytes waiting to be offered, and pieces the block still owes us.
   req_type pending_bytes[$];
   rsp_type expected_pieces[$];
   int queued_items = 0;
   int mismatch_count = 0;

   // Idle percentages for each side; changed between phases.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Long hold-off control for the receiver.
   logic hold_trigger = 1'b0;
   logic hold_done = 1'b0;
   int hold_left = 0;

   // Shadow copy of the registers, as last written.
   logic [63:0] cfg_a_low = '0;
   logic [63:0] cfg_a_high = '0;
   logic [4:0]  cfg_a_len = '0;
   logic [63:0] cfg_b_low = '0;
   logic [63:0] cfg_b_high = '0;
   logic [4:0]  cfg_b_len = '0;
   logic        cfg_ignore_case = 1'b0;

   // Shadow piece state, at the reset values.
   logic [15:0] search_vec = '0;
   logic [15:0] boundary_vec = '0;
   logic        search_hit = 1'b0;
   logic        boundary_hit = 1'b0;
   logic        blank_so_far = 1'b1;
   logic        text_ended = 1'b0;
   int          piece_bytes = 0;
   logic [23:0] piece_count = '0;

   line_substring_match u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic int clamp_length(input logic [4:0] len_reg);
      return (len_reg > PATTERN_SLOTS) ? PATTERN_SLOTS : int'(len_reg);
   endfunction

   function automatic logic [7:0] fold_letter(input logic [7:0] c, input logic ic);
      if (ic && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

   function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                               input int k);
      return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
   endfunction

   // Advance one partial-match vector by one text byte: bit k means the first
   // k+1 pattern bytes end at this byte.
   function automatic logic [15:0] shift_and(input logic [15:0] vec, input logic [63:0] lo,
                                             input logic [63:0] hi, input int eff,
                                             input logic [7:0] c, input logic ic);
      logic [15:0] hits;
      hits = '0;
      if (eff == 0) begin
         return '0;
      end
      for (int k = 0; k < eff; k++) begin
         if (fold_letter(pattern_byte(lo, hi, k), ic) == fold_letter(c, ic)) begin
            hits[k] = 1'b1;
         end
      end
      return ((vec << 1) | 16'd1) & hits;
   endfunction

   // Fold one accepted text byte into the shadow state; queue a result when
   // the piece closes.
   task automatic absorb_text_byte(input req_type item);
      logic [7:0] c;
      rsp_type piece;
      int a_eff;
      int b_eff;
      c = item.text_byte;
      a_eff = clamp_length(cfg_a_len);
      b_eff = clamp_length(cfg_b_len);
      // A NUL hides the rest of the piece from matching and the blank test.
      if (c == CHAR_NUL) begin
         text_ended = 1'b1;
      end
      if (!text_ended) begin
         search_vec = shift_and(search_vec, cfg_a_low, cfg_a_high, a_eff, c, cfg_ignore_case);
         if (a_eff != 0 && search_vec[a_eff-1]) begin
            search_hit = 1'b1;
         end
         boundary_vec = shift_and(boundary_vec, cfg_b_low, cfg_b_high, b_eff, c,
                                  cfg_ignore_case);
         if (b_eff != 0 && boundary_vec[b_eff-1]) begin
            boundary_hit = 1'b1;
         end
         if (c != CHAR_SPACE && c != CHAR_TAB && c != CHAR_LF) begin
            blank_so_far = 1'b0;
         end
      end
      piece_bytes++;
      if (item.end_of_input || c == CHAR_LF || piece_bytes >= LINE_SPLIT_BYTES) begin
         // Empty patterns report a hit on every piece.
         piece.has_search_pattern   = search_hit || a_eff == 0;
         piece.has_boundary_pattern = boundary_hit || b_eff == 0;
         piece.is_blank             = blank_so_far;
         piece.piece_length         = piece_bytes[7:0];
         piece.piece_index          = piece_count;
         expected_pieces.push_back(piece);
         piece_count++;
         search_vec   = '0;
         boundary_vec = '0;
         search_hit   = 1'b0;
         boundary_hit = 1'b0;
         blank_so_far = 1'b1;
         text_ended   = 1'b0;
         piece_bytes  = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer the next pending byte, hold it until taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_text
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_text_byte(req_data);
         end
         // The slot is free when nothing is offered or the offer was just taken.
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Count down the long hold-off once it is armed.
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger && !hold_done) begin
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver readiness: random stalls, forced low during the hold-off.
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: check each taken result against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pieces.size() == 0) begin
            report_mismatch("unexpected piece, index", 32'(rsp_data.piece_index), 32'd0);
         end else begin
            want = expected_pieces.pop_front();
            if (rsp_data.has_search_pattern !== want.has_search_pattern) begin
               report_mismatch("has_search_pattern", 32'(rsp_data.has_search_pattern),
                               32'(want.has_search_pattern));
            end
            if (rsp_data.has_boundary_pattern !== want.has_boundary_pattern) begin
               report_mismatch("has_boundary_pattern", 32'(rsp_data.has_boundary_pattern),
                               32'(want.has_boundary_pattern));
            end
            if (rsp_data.is_blank !== want.is_blank) begin
               report_mismatch("is_blank", 32'(rsp_data.is_blank), 32'(want.is_blank));
            end
            if (rsp_data.piece_length !== want.piece_length) begin
               report_mismatch("piece_length", 32'(rsp_data.piece_length),
                               32'(want.piece_length));
            end
            if (rsp_data.piece_index !== want.piece_index) begin
               report_mismatch("piece_index", 32'(rsp_data.piece_index),
                               32'(want.piece_index));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Register writes; call just after the clock rises, lower csr_valid after the last.
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      // Mirror the write once the block has taken it.
      case (idx)
         CSR_PATTERN_A_LOW:    cfg_a_low = value;
         CSR_PATTERN_A_HIGH:   cfg_a_high = value;
         CSR_PATTERN_A_LENGTH: cfg_a_len = value[4:0];
         CSR_PATTERN_B_LOW:    cfg_b_low = value;
         CSR_PATTERN_B_HIGH:   cfg_b_high = value;
         CSR_PATTERN_B_LENGTH: cfg_b_len = value[4:0];
         CSR_IGNORE_CASE:      cfg_ignore_case = value[0];
         default: ;
      endcase
   endtask

   task automatic program_pattern(input logic boundary, input logic [127:0] bytes_w,
                                  input logic [4:0] len_reg);
      write_reg(boundary ? CSR_PATTERN_B_LOW : CSR_PATTERN_A_LOW, bytes_w[63:0]);
      write_reg(boundary ? CSR_PATTERN_B_HIGH : CSR_PATTERN_A_HIGH, bytes_w[127:64]);
      write_reg(boundary ? CSR_PATTERN_B_LENGTH : CSR_PATTERN_A_LENGTH, {59'd0, len_reg});
   endtask

   // Pattern bytes drawn mostly from a tiny mixed-case alphabet so text hits
   // them often; bytes past the length are arbitrary.
   function automatic logic [127:0] random_pattern(input int eff, input int zero_at);
      logic [127:0] p;
      logic [7:0] c;
      for (int k = 0; k < PATTERN_SLOTS; k++) begin
         if (k < eff) begin
            if ($urandom_range(9) < 8) begin
               c = 8'h61 + 8'($urandom_range(3));
               if ($urandom_range(1) == 1) begin
                  c = c - CASE_OFFSET;
               end
            end else begin
               c = 8'($urandom_range(255, 1));
            end
         end else begin
            c = 8'($urandom_range(255));
         end
         p[8*k +: 8] = c;
      end
      if (zero_at >= 0) begin
         p[8*zero_at +: 8] = CHAR_NUL;
      end
      return p;
   endfunction

   // Write both patterns and the case flag; zero_at < 0 means no NUL in the pattern.
   task automatic configure(input int a_len, input int a_zero, input int b_len,
                            input int b_zero, input logic ic);
      program_pattern(1'b0, random_pattern(clamp_length(5'(a_len)), a_zero), 5'(a_len));
      program_pattern(1'b1, random_pattern(clamp_length(5'(b_len)), b_zero), 5'(b_len));
      write_reg(CSR_IGNORE_CASE, {63'd0, ic});
      csr_valid <= 1'b0;
   endtask

   // Wait until every byte is taken and every result checked, then let the pipeline drain.
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_pieces.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   task automatic add_item(input logic [7:0] b, input logic eoi);
      req_type item;
      item.text_byte    = b;
      item.end_of_input = eoi;
      pending_bytes.push_back(item);
      queued_items++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_item(s[i], 1'b0);
      end
   endtask

   // One text line: letters, whitespace, stray bytes and copies of the
   // configured patterns (some case-flipped, some cut short by one byte).
   task automatic add_random_line();
      int n;
      int i;
      int r;
      int eff;
      int m;
      logic which;
      logic only_blank;
      logic [7:0] b;
      logic [7:0] lower;
      r = $urandom_range(19);
      // Few lines run past the split point; most stay short.
      n = (r == 0) ? $urandom_range(320, 200) : $urandom_range(30);
      only_blank = (r == 1);
      i = 0;
      while (i < n) begin
         r = $urandom_range(15);
         if (only_blank) begin
            add_item($urandom_range(1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
            i++;
         end else if (r < 3) begin
            which = 1'($urandom_range(1));
            eff = clamp_length(which ? cfg_b_len : cfg_a_len);
            m = (r == 0 && eff > 1) ? eff - 1 : eff;
            for (int k = 0; k < m; k++) begin
               b = which ? pattern_byte(cfg_b_low, cfg_b_high, k)
                         : pattern_byte(cfg_a_low, cfg_a_high, k);
               lower = b | CASE_OFFSET;
               if (lower >= CHAR_UPPER_A + CASE_OFFSET && lower <= CHAR_UPPER_Z + CASE_OFFSET
                   && $urandom_range(3) == 0) begin
                  b = b ^ CASE_OFFSET;
               end
               add_item(b, 1'b0);
            end
            i += (m == 0) ? 1 : m;
         end else if (r < 6) begin
            add_item($urandom_range(1) ? CHAR_SPACE : CHAR_TAB, 1'b0);
            i++;
         end else if (r < 10) begin
            b = 8'h61 + 8'($urandom_range(3));
            add_item($urandom_range(1) ? b : b - CASE_OFFSET, 1'b0);
            i++;
         end else if (r < 15) begin
            add_item(8'($urandom_range(126, 33)), 1'b0);
            i++;
         end else begin
            // Any byte at all, NUL and newline included; now and then flag end of input.
            add_item(8'($urandom_range(255)), $urandom_range(7) == 0);
            i++;
         end
      end
      r = $urandom_range(9);
      if (r < 7) begin
         add_item(CHAR_LF, 1'b0);
      end else if (r < 9) begin
         add_item(8'($urandom_range(255)), 1'b1);
      end
      // Otherwise run on into the next line.
   endtask

   // Fill one block of random lines and close the last piece so that no
   // partial piece straddles a register change.
   task automatic add_random_block();
      int start;
      start = queued_items;
      while (queued_items - start < BLOCK_ITEMS) begin
         add_random_line();
      end
      add_item(8'($urandom_range(255)), 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_sequence
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 37;
      recv_idle_pct <= 86;

      // Reset registers: both patterns empty, so every piece hits.
      add_text("q\n");
      wait_quiet();

      // Search "HeLLo" with case folding, boundary a full sixteen bytes.
      program_pattern(1'b0, {88'd0, "oLLeH"}, 5'd5);
      program_pattern(1'b1, {"fedcba9876543210"}, 5'd16);
      write_reg(CSR_IGNORE_CASE, 64'd1);
      csr_valid <= 1'b0;
      add_text("xhello\n");
      // Whitespace-only piece.
      add_text("\t \n");
      // NUL in the middle hides the rest from the match.
      add_item(8'h68, 1'b0);
      add_item(CHAR_NUL, 1'b0);
      add_text("ello\n");
      // Text after a NUL does not clear the blank flag.
      add_item(CHAR_SPACE, 1'b0);
      add_item(CHAR_NUL, 1'b0);
      add_text("x\n");
      // All-ones byte closing the input.
      add_item(8'hFF, 1'b1);
      wait_quiet();

      // Sender idles lightly, receiver heavily.
      configure(3, -1, 16, -1, 1'b1);
      add_random_block();
      wait_quiet();
      // Length above the pattern width acts as full width; empty boundary.
      configure(31, -1, 0, -1, 1'b0);
      add_random_block();
      wait_quiet();

      // Swap the idle rates.
      send_idle_pct <= 86;
      recv_idle_pct <= 37;
      configure(1, -1, 2, -1, 1'b1);
      add_random_block();
      wait_quiet();
      // A NUL inside the search pattern can never match.
      configure(16, 5, 4, -1, 1'b0);
      add_random_block();
      wait_quiet();

      // No idling; back up the block with a long receiver hold-off while a
      // burst of short lines keeps arriving.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      configure(0, -1, 20, -1, 1'b1);
      for (int i = 0; i < 40; i++) begin
         add_text("ab\n");
      end
      hold_trigger <= 1'b1;
      add_random_block();
      wait_quiet();
      configure($urandom_range(31), -1, $urandom_range(31),
                $urandom_range(1) ? int'($urandom_range(15)) : -1, 1'($urandom_range(1)));
      add_random_block();
      wait_quiet();

      if (mismatch_count == 0) begin
         $display("line_substring_match test passed");
      end else begin
         $display("line_substring_match test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #1000000;
      $display("line_substring_match test failed");
      $finish;
   end

endmodule
